/* hdl/slm_pkg.sv */
// Shared types, constants and the breathing curve table for the status LED mode controller.
package slm_pkg;

  localparam int CURVE_ENTRIES = 513;
  localparam int SPAN_MAX = (CURVE_ENTRIES > 1) ? CURVE_ENTRIES - 1 : 1;
  localparam int IDX_W = $clog2(CURVE_ENTRIES);
  localparam int PHASE_W = 16;
  localparam int SINCE_W = 17;
  localparam int PROD_W = PHASE_W + IDX_W;
  localparam int QPAD_W = PHASE_W - IDX_W;
  localparam int CNT_W = 4;
  localparam int MOD_STEPS = PHASE_W;
  localparam int DIV_STEPS = IDX_W;

  localparam logic [63:0] Q28_ONE = 64'd1 << 28;

  localparam logic [15:0] TIMEOUT_RST = 16'd2000;
  localparam logic [15:0] HOLD_RST = 16'd2000;
  localparam logic [15:0] BLINK_RST = 16'd150;
  localparam logic [15:0] BREATHE_RST = 16'd2500;
  localparam logic [15:0] PERIOD_MIN = 16'd2;
  localparam logic [SINCE_W-1:0] SINCE_MAX = '1;
  localparam logic [15:0] ELAPSED_MAX = '1;

  localparam logic [7:0] LEVEL_FULL = 8'd255;
  localparam logic [7:0] ORANGE_GREEN = 8'd50;

  // command bytes
  localparam logic [7:0] CMD_OFF = 8'h6E;   // 'n'
  localparam logic [7:0] CMD_DIS = 8'h64;   // 'd'
  localparam logic [7:0] CMD_EN = 8'h65;    // 'e'
  localparam logic [7:0] CMD_STOP = 8'h73;  // 's'

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_BYTE = 1'b1;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_HOLD = 2'd1,
    REG_BLINK = 2'd2,
    REG_BREATHE = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_DIS = 2'd1,
    MODE_EN = 2'd2,
    MODE_STOP = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MOD,
    ST_FOLD,
    ST_MUL,
    ST_DIV,
    ST_ROM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       action;
    logic [7:0] cmd_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] mode_now;
  } out_t;

  typedef struct packed {
    logic upd;
    logic mod_load;
    logic direct_load;
    logic div_step;
    logic fold;
    logic mul_load;
    logic rom_read;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mode_dis;
    logic phase_ge_per;
  } sts_t;

  typedef logic [CURVE_ENTRIES-1:0][7:0] curve_rom_t;

  // e^y in Q28: Taylor series at y/8, then squared three times
  function automatic logic [63:0] exp_q28(input logic [63:0] y);
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    z = y >> 3;
    sum = Q28_ONE;
    term = Q28_ONE;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * z) >> 28) / 64'(k);
      sum = sum + term;
    end
    for (int r = 0; r < 3; r++) begin
      sum = (sum * sum) >> 28;
    end
    return sum;
  endfunction

  localparam logic [63:0] CURVE_TOP = exp_q28(64'd3 << 28) - Q28_ONE;
  localparam logic [63:0] CurveDen = (CURVE_TOP != 64'd0) ? CURVE_TOP : 64'd1;

  function automatic curve_rom_t build_curve();
    curve_rom_t  rom;
    logic [63:0] y;
    logic [63:0] v;
    for (int i = 0; i < CURVE_ENTRIES; i++) begin
      y = ((64'd3 * 64'(i)) << 28) / 64'(SPAN_MAX);
      v = ((exp_q28(y) - Q28_ONE) * 64'd255) / CurveDen;
      rom[i] = (v > 64'd255) ? 8'd255 : v[7:0];
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_curve();

endpackage

/* hdl/slm_ctrl.sv */
// Sequencer for the status LED mode controller: handshakes, step counter, datapath commands.
module slm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  slm_pkg::sts_t sts,
  output slm_pkg::cmd_t cmd
);

  localparam logic [slm_pkg::CNT_W-1:0] MOD_LAST = slm_pkg::CNT_W'(slm_pkg::MOD_STEPS - 1);
  localparam logic [slm_pkg::CNT_W-1:0] DIV_LAST = slm_pkg::CNT_W'(slm_pkg::DIV_STEPS - 1);

  slm_pkg::state_t state;
  slm_pkg::state_t state_next;
  logic [slm_pkg::CNT_W-1:0] cnt;
  logic [slm_pkg::CNT_W-1:0] cnt_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      slm_pkg::ST_IDLE: begin
        if (in_valid) state_next = slm_pkg::ST_DECIDE;
      end
      slm_pkg::ST_DECIDE: begin
        if (!sts.mode_dis) state_next = slm_pkg::ST_EMIT;
        else if (sts.phase_ge_per) state_next = slm_pkg::ST_MOD;
        else state_next = slm_pkg::ST_FOLD;
      end
      slm_pkg::ST_MOD: begin
        if (cnt == MOD_LAST) state_next = slm_pkg::ST_FOLD;
      end
      slm_pkg::ST_FOLD: state_next = slm_pkg::ST_MUL;
      slm_pkg::ST_MUL: state_next = slm_pkg::ST_DIV;
      slm_pkg::ST_DIV: begin
        if (cnt == DIV_LAST) state_next = slm_pkg::ST_ROM;
      end
      slm_pkg::ST_ROM: state_next = slm_pkg::ST_EMIT;
      slm_pkg::ST_EMIT: begin
        if (out_free) state_next = slm_pkg::ST_IDLE;
      end
      default: state_next = slm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      slm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.upd = in_valid;
      end
      slm_pkg::ST_DECIDE: begin
        cmd.mod_load = sts.mode_dis && sts.phase_ge_per;
        cmd.direct_load = sts.mode_dis && !sts.phase_ge_per;
      end
      slm_pkg::ST_MOD: cmd.div_step = 1'b1;
      slm_pkg::ST_FOLD: cmd.fold = 1'b1;
      slm_pkg::ST_MUL: cmd.mul_load = 1'b1;
      slm_pkg::ST_DIV: cmd.div_step = 1'b1;
      slm_pkg::ST_ROM: cmd.rom_read = 1'b1;
      slm_pkg::ST_EMIT: cmd.emit = out_free;
      default: cmd = '0;
    endcase
  end

  // step counter runs only while iterating, zero elsewhere
  assign cnt_next = (state == slm_pkg::ST_MOD || state == slm_pkg::ST_DIV) ?
                    cnt + 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slm_pkg::ST_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* hdl/slm_datapath.sv */
// Datapath: config registers, mode and timer state, phase divider, curve ROM, result register.
module slm_datapath (
  input  logic          clk,
  input  logic          rst,
  input  slm_pkg::cmd_t cmd,
  output slm_pkg::sts_t sts,
  input  slm_pkg::in_t  in_data,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output slm_pkg::out_t out_data
);

  // config
  logic [15:0] timeout_ms;
  logic [15:0] estop_hold_ms;
  logic [15:0] blink_half_period_ms;
  logic [15:0] breathe_period_ms;

  // mode and timers
  slm_pkg::mode_t mode;
  logic [slm_pkg::SINCE_W-1:0] since_command;
  logic [15:0] blink_elapsed;
  logic blink_lit;
  logic [slm_pkg::PHASE_W-1:0] breathe_phase;
  logic [15:0] hold_left;

  slm_pkg::mode_t mode_next;
  logic [slm_pkg::SINCE_W-1:0] since_command_next;
  logic [15:0] blink_elapsed_next;
  logic blink_lit_next;
  logic [slm_pkg::PHASE_W-1:0] breathe_phase_next;
  logic [15:0] hold_left_next;

  // breathing arithmetic
  logic [slm_pkg::PHASE_W-1:0] rem;
  logic [slm_pkg::PHASE_W-1:0] quo;
  logic [slm_pkg::PHASE_W-1:0] fold_u;
  logic [7:0] level;

  logic [15:0] period_eff;
  logic [slm_pkg::PHASE_W:0] phase_inc;
  logic [slm_pkg::SINCE_W-1:0] since_t;
  logic [15:0] elapsed_t;
  slm_pkg::mode_t mode_t1;
  logic [slm_pkg::PHASE_W:0] shifted;
  logic take;
  logic [slm_pkg::PHASE_W:0] diff;
  logic [slm_pkg::PHASE_W:0] dbl;
  logic [15:0] gap;
  logic [slm_pkg::PROD_W-1:0] prod;

  assign period_eff = (breathe_period_ms < slm_pkg::PERIOD_MIN) ?
                      slm_pkg::PERIOD_MIN : breathe_period_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= slm_pkg::TIMEOUT_RST;
      estop_hold_ms <= slm_pkg::HOLD_RST;
      blink_half_period_ms <= slm_pkg::BLINK_RST;
      breathe_period_ms <= slm_pkg::BREATHE_RST;
    end else if (cfg_valid) begin
      unique case (slm_pkg::reg_idx_t'(cfg_index))
        slm_pkg::REG_TIMEOUT: timeout_ms <= cfg_data;
        slm_pkg::REG_HOLD: estop_hold_ms <= cfg_data;
        slm_pkg::REG_BLINK: blink_half_period_ms <= cfg_data;
        slm_pkg::REG_BREATHE: breathe_period_ms <= cfg_data;
        default: timeout_ms <= timeout_ms;
      endcase
    end
  end

  // one request: tick or byte, then the blink toggle on the updated state
  always_comb begin
    since_t = since_command;
    elapsed_t = blink_elapsed;
    mode_t1 = mode;
    breathe_phase_next = breathe_phase;
    hold_left_next = hold_left;
    phase_inc = {1'b0, breathe_phase} + 1'b1;
    if (in_data.action == slm_pkg::ACT_TICK) begin
      if (since_command != slm_pkg::SINCE_MAX) since_t = since_command + 1'b1;
      if (blink_elapsed != slm_pkg::ELAPSED_MAX) elapsed_t = blink_elapsed + 1'b1;
      if (phase_inc >= {1'b0, period_eff}) breathe_phase_next = '0;
      else breathe_phase_next = phase_inc[slm_pkg::PHASE_W-1:0];
      if (mode == slm_pkg::MODE_STOP) begin
        if (hold_left <= 16'd1) begin
          hold_left_next = '0;
          mode_t1 = slm_pkg::MODE_OFF;
        end else begin
          hold_left_next = hold_left - 1'b1;
        end
      end else if (mode != slm_pkg::MODE_OFF && since_t > {1'b0, timeout_ms}) begin
        mode_t1 = slm_pkg::MODE_OFF;
      end
    end else if (mode != slm_pkg::MODE_STOP) begin
      since_t = '0;
      case (in_data.cmd_byte)
        slm_pkg::CMD_OFF: mode_t1 = slm_pkg::MODE_OFF;
        slm_pkg::CMD_DIS: mode_t1 = slm_pkg::MODE_DIS;
        slm_pkg::CMD_EN: mode_t1 = slm_pkg::MODE_EN;
        slm_pkg::CMD_STOP: begin
          mode_t1 = slm_pkg::MODE_STOP;
          hold_left_next = estop_hold_ms;
        end
        default: mode_t1 = mode;
      endcase
    end
    mode_next = mode_t1;
    since_command_next = since_t;
    blink_elapsed_next = elapsed_t;
    blink_lit_next = blink_lit;
    if (mode_t1 == slm_pkg::MODE_EN && elapsed_t >= blink_half_period_ms) begin
      blink_lit_next = !blink_lit;
      blink_elapsed_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= slm_pkg::MODE_OFF;
      since_command <= '0;
      blink_elapsed <= '0;
      blink_lit <= 1'b0;
      breathe_phase <= '0;
      hold_left <= '0;
    end else if (cmd.upd) begin
      mode <= mode_next;
      since_command <= since_command_next;
      blink_elapsed <= blink_elapsed_next;
      blink_lit <= blink_lit_next;
      breathe_phase <= breathe_phase_next;
      hold_left <= hold_left_next;
    end
  end

  assign sts.mode_dis = (mode == slm_pkg::MODE_DIS);
  assign sts.phase_ge_per = (breathe_phase >= period_eff);

  // restoring divider step; remainder stays below the period
  assign shifted = {rem, quo[slm_pkg::PHASE_W-1]};
  assign take = (shifted >= {1'b0, period_eff});
  assign diff = shifted - {1'b0, period_eff};

  // triangle fold of the phase
  assign dbl = {rem, 1'b0};
  assign gap = period_eff - rem;

  assign prod = slm_pkg::PROD_W'(fold_u) * slm_pkg::PROD_W'(slm_pkg::SPAN_MAX);

  always_ff @(posedge clk) begin
    if (cmd.mod_load) begin
      rem <= '0;
      quo <= breathe_phase;
    end else if (cmd.direct_load) begin
      rem <= breathe_phase;
    end else if (cmd.div_step) begin
      rem <= take ? diff[slm_pkg::PHASE_W-1:0] : shifted[slm_pkg::PHASE_W-1:0];
      quo <= {quo[slm_pkg::PHASE_W-2:0], take};
    end else if (cmd.mul_load) begin
      // top bits start below the period, so IDX_W steps give the index
      rem <= prod[slm_pkg::PROD_W-1:slm_pkg::IDX_W];
      quo <= {prod[slm_pkg::IDX_W-1:0], {slm_pkg::QPAD_W{1'b0}}};
    end
    if (cmd.fold) begin
      fold_u <= (dbl < {1'b0, period_eff}) ? dbl[slm_pkg::PHASE_W-1:0] : {gap[14:0], 1'b0};
    end
    if (cmd.rom_read) begin
      level <= slm_pkg::CURVE_ROM[quo[slm_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.mode_now <= mode;
      out_data.red <= '0;
      out_data.green <= '0;
      out_data.blue <= '0;
      unique case (mode)
        slm_pkg::MODE_OFF: out_data.red <= '0;
        slm_pkg::MODE_DIS: out_data.blue <= level;
        slm_pkg::MODE_EN: begin
          if (blink_lit) begin
            out_data.red <= slm_pkg::LEVEL_FULL;
            out_data.green <= slm_pkg::ORANGE_GREEN;
          end
        end
        slm_pkg::MODE_STOP: out_data.red <= slm_pkg::LEVEL_FULL;
        default: out_data.red <= '0;
      endcase
    end
  end

endmodule

/* hdl/status_led_mode_controller_unit.sv */
// Top level of the status LED mode controller: sequencer plus datapath.
//
//   channel  signals                                  direction
//   in       in_valid, in_ready, in_data              tick or command byte request
//   out      out_valid, out_ready, out_data           pixel color and mode
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data register write, always ready
//
// Off, blink and estop requests pass DECIDE and EMIT before the result is registered.
// Breathing requests pass DECIDE, FOLD, MUL, the divider, ROM and EMIT, plus a modulo
// pass when the phase is at or beyond a new period; the divider gives one bit per cycle.
// Reset is synchronous and loads the register defaults; no clearing pass.
// A result waits in the output register while the next request is accepted;
// a second result waits in the sequencer until the first one is taken.
module status_led_mode_controller_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  slm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output slm_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  slm_pkg::cmd_t cmd;
  slm_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  slm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  slm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_stop_red: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.mode_now == slm_pkg::MODE_STOP |->
      out_data.red == slm_pkg::LEVEL_FULL && out_data.green == 8'd0 && out_data.blue == 8'd0)
    else $error("estop result is not full red");

  a_off_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.mode_now == slm_pkg::MODE_OFF |->
      out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0)
    else $error("off result is not dark");

endmodule
